// ===== src/lek_pkg.sv =====
// lek_pkg: shared types and constants of the line editor
// no dependencies; used by scoped names by every file of the block but lek_ram
`default_nettype none

package lek_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned LIMIT_W    = 6;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned LINE_DEPTH = 63;

  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR     = 8'd10;
  localparam logic [CHAR_W-1:0]  ERASE_CHAR_RST   = 8'd35;
  localparam logic [CHAR_W-1:0]  KILL_CHAR_RST    = 8'd47;
  localparam logic [CHAR_W-1:0]  BREAK_CHAR_RST   = 8'd64;
  localparam logic [LIMIT_W-1:0] LINE_LIMIT_RST   = 6'd63;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CHAR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL_CHAR  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_CHAR = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT = 8'd3;

  // depth of the command queue between front and back
  localparam int unsigned CMD_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_FLUSH = 2'd0,
    OP_ERASE = 2'd1,
    OP_KILL  = 2'd2,
    OP_STORE = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/lek_ram.sv =====
// lek_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module lek_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 63,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/lek_front.sv =====
// lek_front: accepts input characters, classifies them into editing commands
// and queues them for the back end; depends on lek_pkg
`default_nettype none

module lek_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [lek_pkg::CHAR_W-1:0] in_char_i,
  input  wire logic [lek_pkg::CHAR_W-1:0] erase_char_i,
  input  wire logic [lek_pkg::CHAR_W-1:0] kill_char_i,
  input  wire logic [lek_pkg::CHAR_W-1:0] break_char_i,
  output lek_pkg::cmd_t                   cmd_o,
  output logic                            cmd_valid_o,
  input  wire logic                       cmd_ready_i
);

  localparam int unsigned QD  = lek_pkg::CMD_QUEUE_DEPTH;
  localparam int unsigned PW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned CW  = $clog2(QD + 1);

  lek_pkg::cmd_t    queue_q [QD];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  lek_pkg::cmd_t    new_cmd;
  logic             do_push, do_pop;

  // priority: newline or break, then erase, then kill
  always_comb begin
    new_cmd.ch = in_char_i;
    if (in_char_i == lek_pkg::NEWLINE_CHAR || in_char_i == break_char_i) begin
      new_cmd.op = lek_pkg::OP_FLUSH;
    end else if (in_char_i == erase_char_i) begin
      new_cmd.op = lek_pkg::OP_ERASE;
    end else if (in_char_i == kill_char_i) begin
      new_cmd.op = lek_pkg::OP_KILL;
    end else begin
      new_cmd.op = lek_pkg::OP_STORE;
    end
  end

  assign full        = (count_q == CW'(QD));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== src/lek_back.sv =====
// lek_back: executes editing commands on the line store and drives the
// result register; depends on lek_pkg and lek_ram
`default_nettype none

module lek_back #(
  parameter int unsigned LINE_DEPTH = lek_pkg::LINE_DEPTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lek_pkg::cmd_t               cmd_i,
  input  wire logic                        cmd_valid_i,
  output logic                             cmd_ready_o,
  input  wire logic [lek_pkg::LIMIT_W-1:0] line_limit_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic      [lek_pkg::CHAR_W-1:0]  out_char_o,
  output logic                             last_o
);

  localparam int unsigned AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned LW = $clog2(LINE_DEPTH + 1);

  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_READ = 4'b0010,
    BK_EMIT = 4'b0100,
    BK_NL   = 4'b1000
  } back_state_e;

  back_state_e                 state_q, state_d;
  logic [LW-1:0]               len_q, len_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic                        pend_q, pend_d;
  logic [lek_pkg::CHAR_W-1:0]  pch_q, pch_d;
  logic                        out_valid_q, out_valid_d;
  logic [lek_pkg::CHAR_W-1:0]  out_char_q, out_char_d;
  logic                        out_last_q, out_last_d;
  logic [LW-1:0]               eff_limit;
  logic                        out_free;
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr;
  logic [lek_pkg::CHAR_W-1:0]  ram_wdata, ram_rdata;

  // zero acts as one, anything above the store depth as the depth
  always_comb begin
    if (line_limit_i == '0) begin
      eff_limit = LW'(1);
    end else if (line_limit_i > lek_pkg::LIMIT_W'(LINE_DEPTH)) begin
      eff_limit = LW'(LINE_DEPTH);
    end else begin
      eff_limit = LW'(line_limit_i);
    end
  end

  assign out_free    = !out_valid_q || pop;
  assign cmd_ready_o = (state_q == BK_IDLE);
  assign empty       = !out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pch_d       = pch_q;
    out_valid_d = out_valid_q && !pop;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = len_q[AW-1:0];
    ram_wdata   = cmd_i.ch;
    ram_re      = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            lek_pkg::OP_FLUSH: begin
              idx_d   = '0;
              state_d = (len_q == '0) ? BK_NL : BK_READ;
            end
            lek_pkg::OP_ERASE: begin
              if (len_q != '0) begin
                len_d = len_q - LW'(1);
              end
            end
            lek_pkg::OP_KILL: begin
              len_d = '0;
            end
            lek_pkg::OP_STORE: begin
              if (len_q >= eff_limit) begin
                // line full: flush first, keep the character for later
                pend_d  = 1'b1;
                pch_d   = cmd_i.ch;
                idx_d   = '0;
                state_d = BK_READ;
              end else begin
                ram_we = 1'b1;
                len_d  = len_q + LW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        ram_re  = 1'b1;
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = ram_rdata;
          out_last_d  = 1'b0;
          if (LW'(idx_q) + LW'(1) == len_q) begin
            state_d = BK_NL;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = BK_READ;
          end
        end
      end
      BK_NL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = lek_pkg::NEWLINE_CHAR;
          out_last_d  = 1'b1;
          len_d       = '0;
          if (pend_q) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = pch_q;
            len_d     = LW'(1);
          end
          pend_d  = 1'b0;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      len_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pch_q      <= pch_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  lek_ram #(
    .WIDTH (lek_pkg::CHAR_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== src/line_editor_erase_kill.sv =====
// line editor with erase, kill and break: configuration registers, front
// classifier with command queue, and back executor; depends on lek_pkg,
// lek_front and lek_back; a command waits in the front queue while the
// back end is busy; a flush prints each character through the store's read
// register and then the result register, then the closing newline (alone
// for an empty line); erase, kill and ordinary stores leave the back end
// idle and ready for the next command
// reset: asynchronous, clears the line length, command queue and result register
`default_nettype none

module line_editor_erase_kill #(
  parameter int unsigned LINE_DEPTH = lek_pkg::LINE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [lek_pkg::CHAR_W-1:0]    in_char_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic      [lek_pkg::CHAR_W-1:0]    out_char_o,
  output logic                               last_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lek_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [lek_pkg::CHAR_W-1:0]    cfg_data_i
);

  logic [lek_pkg::CHAR_W-1:0]  erase_char_q, kill_char_q, break_char_q;
  logic [lek_pkg::LIMIT_W-1:0] line_limit_q;
  lek_pkg::cmd_t               cmd;
  logic                        cmd_valid, cmd_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_char_q <= lek_pkg::ERASE_CHAR_RST;
      kill_char_q  <= lek_pkg::KILL_CHAR_RST;
      break_char_q <= lek_pkg::BREAK_CHAR_RST;
      line_limit_q <= lek_pkg::LINE_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lek_pkg::CFG_ERASE_CHAR: erase_char_q <= cfg_data_i;
        lek_pkg::CFG_KILL_CHAR:  kill_char_q  <= cfg_data_i;
        lek_pkg::CFG_BREAK_CHAR: break_char_q <= cfg_data_i;
        lek_pkg::CFG_LINE_LIMIT: line_limit_q <= cfg_data_i[lek_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  lek_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_char_i    (in_char_i),
    .erase_char_i (erase_char_q),
    .kill_char_i  (kill_char_q),
    .break_char_i (break_char_q),
    .cmd_o        (cmd),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready)
  );

  lek_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .line_limit_i (line_limit_q),
    .empty        (empty),
    .pop          (pop),
    .out_char_o   (out_char_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ===== src/lek_checker.sv =====
// lek_checker: port-level assertions for the line editor, bound to the top
// level; depends on lek_pkg
`default_nettype none

module lek_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          empty,
  input wire logic                          pop,
  input wire logic [lek_pkg::CHAR_W-1:0]    out_char_o,
  input wire logic                          last_o,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o
);

  // a newline is never stored, so it shows up only as the end of a run
  a_last_is_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_o == (out_char_o == lek_pkg::NEWLINE_CHAR)))
    else $error("last flag and newline disagree");

  // a waiting result holds while not taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_char_o) && $stable(last_o)))
    else $error("waiting result changed");

  // configuration writes are never stalled
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

  // nothing is emitted right out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> empty)
    else $error("result present after reset");

endmodule

bind line_editor_erase_kill lek_checker u_lek_checker (.*);

`default_nettype wire

// ===== tb/line_editor_erase_kill_tb.sv =====
// line_editor_erase_kill_tb: self-checking bench for the erase/kill/break line editor
// predicts every printed character from its own copy of the line and the registers
// depends on lek_pkg and line_editor_erase_kill; no files, no arguments
`timescale 1ns / 100ps

module line_editor_erase_kill_tb;

  localparam int DEPTH         = lek_pkg::LINE_DEPTH;
  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [lek_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 8'd200;

  typedef struct {
    logic [lek_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } printed_t;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic push        = 1'b0;
  logic pop         = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [lek_pkg::CHAR_W-1:0]    in_char_i   = '0;
  logic [lek_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [lek_pkg::CHAR_W-1:0]    cfg_data_i  = '0;
  logic full, empty, last_o, cfg_ready_o;
  logic [lek_pkg::CHAR_W-1:0] out_char_o;

  // shadow registers and line
  logic [lek_pkg::CHAR_W-1:0]  erase_reg, kill_reg, break_reg;
  logic [lek_pkg::LIMIT_W-1:0] limit_reg;
  logic [lek_pkg::CHAR_W-1:0]  line_buf [DEPTH];
  int line_len;

  printed_t printed_q [$];
  printed_t head;
  int mismatch_count = 0;
  int send_gap_pct   = 0;
  int pop_stall_pct  = 0;
  int quiet_cycles   = 0;

  line_editor_erase_kill i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_char_i   (in_char_i),
    .empty       (empty),
    .pop         (pop),
    .out_char_o  (out_char_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- prediction

  task automatic print_line();
    for (int i = 0; i < line_len; i++) printed_q.push_back('{ch: line_buf[i], last: 1'b0});
    printed_q.push_back('{ch: lek_pkg::NEWLINE_CHAR, last: 1'b1});
    line_len = 0;
  endtask

  task automatic edit_line(input logic [lek_pkg::CHAR_W-1:0] c);
    lek_pkg::op_e op;
    int cap;
    // newline and break outrank erase, erase outranks kill
    if (c == lek_pkg::NEWLINE_CHAR || c == break_reg) op = lek_pkg::OP_FLUSH;
    else if (c == erase_reg) op = lek_pkg::OP_ERASE;
    else if (c == kill_reg) op = lek_pkg::OP_KILL;
    else op = lek_pkg::OP_STORE;
    cap = (limit_reg == 0) ? 1 : int'(limit_reg);
    if (cap > DEPTH) cap = DEPTH;
    case (op)
      lek_pkg::OP_FLUSH: print_line();
      lek_pkg::OP_ERASE: if (line_len > 0) line_len--;
      lek_pkg::OP_KILL:  line_len = 0;
      default: begin
        // full line (or limit lowered below length) wraps before storing
        if (line_len >= cap) print_line();
        if (line_len < DEPTH) begin
          line_buf[line_len] = c;
          line_len++;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic type_char(input logic [lek_pkg::CHAR_W-1:0] c);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_char_i <= c;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    edit_line(c);
  endtask

  // sender pauses until every expected character is out, then lets the back end drain
  task automatic settle();
    push <= 1'b0;
    while (printed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [lek_pkg::CHAR_W-1:0] erase_c,
                           input logic [lek_pkg::CHAR_W-1:0] kill_c,
                           input logic [lek_pkg::CHAR_W-1:0] break_c,
                           input logic [lek_pkg::LIMIT_W-1:0] limit_c,
                           input bit poke_unused);
    logic [lek_pkg::CFG_IDX_W-1:0] idx [5];
    logic [lek_pkg::CHAR_W-1:0]    val [5];
    int n;
    idx[0] = lek_pkg::CFG_ERASE_CHAR; val[0] = erase_c;
    idx[1] = lek_pkg::CFG_KILL_CHAR;  val[1] = kill_c;
    idx[2] = lek_pkg::CFG_BREAK_CHAR; val[2] = break_c;
    // upper data bits above the limit field are random and must be dropped
    idx[3] = lek_pkg::CFG_LINE_LIMIT; val[3] = {2'($urandom_range(3)), limit_c};
    idx[4] = CFG_UNUSED;              val[4] = 8'($urandom_range(255));
    n = poke_unused ? 5 : 4;
    for (int i = 0; i < n; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx[i])
        lek_pkg::CFG_ERASE_CHAR: erase_reg = val[i];
        lek_pkg::CFG_KILL_CHAR:  kill_reg  = val[i];
        lek_pkg::CFG_BREAK_CHAR: break_reg = val[i];
        lek_pkg::CFG_LINE_LIMIT: limit_reg = val[i][lek_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [lek_pkg::CHAR_W-1:0] any_char();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return lek_pkg::NEWLINE_CHAR;
    if (r < 16) return break_reg;
    if (r < 28) return erase_reg;
    if (r < 33) return kill_reg;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [lek_pkg::CHAR_W-1:0] plain_char();
    logic [lek_pkg::CHAR_W-1:0] c;
    do c = 8'($urandom_range(255));
    while (c == lek_pkg::NEWLINE_CHAR || c == break_reg || c == erase_reg || c == kill_reg);
    return c;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_registers();
    // extremes of the byte, erase and kill on a line and on an empty line
    type_char(8'hFF);
    type_char(8'h00);
    type_char(8'h61);
    type_char(lek_pkg::ERASE_CHAR_RST);
    type_char(8'h62);
    type_char(lek_pkg::NEWLINE_CHAR);
    type_char(lek_pkg::ERASE_CHAR_RST);
    type_char(lek_pkg::KILL_CHAR_RST);
    type_char(lek_pkg::BREAK_CHAR_RST);
    type_char(8'h55);
    type_char(8'hAA);
    type_char(lek_pkg::KILL_CHAR_RST);
    type_char(lek_pkg::BREAK_CHAR_RST);
    settle();
  endtask

  task automatic test_line_limit();
    configure(lek_pkg::ERASE_CHAR_RST, lek_pkg::KILL_CHAR_RST, lek_pkg::BREAK_CHAR_RST,
              6'd1, 1'b1);
    type_char(8'h78);
    type_char(8'h79);
    settle();
    // zero limit behaves as one
    configure(erase_reg, kill_reg, break_reg, 6'd0, 1'b0);
    type_char(8'h7A);
    settle();
    configure(erase_reg, kill_reg, break_reg, 6'd63, 1'b0);
    repeat (4) type_char(plain_char());
    settle();
    // lowering the limit below the current length wraps on the next store
    configure(erase_reg, kill_reg, break_reg, 6'd2, 1'b0);
    type_char(8'h41);
    type_char(break_reg);
    settle();
  endtask

  task automatic test_code_collisions();
    // newline beats erase
    configure(lek_pkg::NEWLINE_CHAR, 8'hFF, 8'h80, 6'd63, 1'b0);
    type_char(8'h61);
    type_char(lek_pkg::NEWLINE_CHAR);
    settle();
    // erase beats kill, break beats both
    configure(8'h00, 8'h00, 8'hFF, 6'd63, 1'b0);
    type_char(8'h72);
    type_char(8'h73);
    type_char(8'h00);
    type_char(8'hFF);
    settle();
    configure(8'h80, 8'h80, 8'h80, 6'd63, 1'b0);
    type_char(8'h6D);
    type_char(8'h80);
    settle();
  endtask

  task automatic test_random_editing();
    logic [lek_pkg::LIMIT_W-1:0] lim;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_gap_pct = 0;  pop_stall_pct = 0;  lim = 6'd1;  end
        1:       begin send_gap_pct = 63; pop_stall_pct = 0;  lim = 6'd63; end
        2:       begin send_gap_pct = 0;  pop_stall_pct = 63; lim = 6'($urandom_range(2, 12)); end
        default: begin send_gap_pct = 6;  pop_stall_pct = 6;  lim = 6'($urandom_range(2, 12)); end
      endcase
      configure((p == 0) ? 8'h00 : 8'($urandom_range(255)),
                (p == 1) ? 8'hFF : 8'($urandom_range(255)),
                8'($urandom_range(255)), lim, 1'b0);
      repeat (5) type_char(any_char());
      settle();
    end
  endtask

  task automatic test_full_line();
    // 63 stored characters, then one more: longest run of 64 characters
    send_gap_pct  = 6;
    pop_stall_pct = 63;
    configure(lek_pkg::ERASE_CHAR_RST, lek_pkg::KILL_CHAR_RST, lek_pkg::BREAK_CHAR_RST,
              6'd63, 1'b0);
    repeat (DEPTH + 1) type_char(plain_char());
    type_char(break_reg);
    settle();
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (printed_q.size() == 0) begin
        $error("out_char: no transaction expected, actual %0h", out_char_o);
        mismatch_count++;
      end else begin
        head = printed_q.pop_front();
        if (out_char_o !== head.ch) begin
          $error("out_char: expected %0h, actual %0h", head.ch, out_char_o);
          mismatch_count++;
        end
        if (last_o !== head.last) begin
          $error("last: expected %0b, actual %0b", head.last, last_o);
          mismatch_count++;
        end
      end
    end
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    erase_reg = lek_pkg::ERASE_CHAR_RST;
    kill_reg  = lek_pkg::KILL_CHAR_RST;
    break_reg = lek_pkg::BREAK_CHAR_RST;
    limit_reg = lek_pkg::LINE_LIMIT_RST;
    line_len  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_registers();
    test_line_limit();
    test_code_collisions();
    test_random_editing();
    test_full_line();

    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
